// ===== rtl/message_queue_with_waiters_top_defines.svh =====
// Assertion macros for the message queue engine.
`ifndef MESSAGE_QUEUE_WITH_WAITERS_TOP_DEFINES_SVH
`define MESSAGE_QUEUE_WITH_WAITERS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define MQW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define MQW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MQW_ASSERT(lbl, prop, msg)
`define MQW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/mqw_pkg.sv =====
// Shared types, field widths and codes of the message queue engine.
`timescale 1ns / 1ps

package mqw_pkg;

	localparam int CMD_W       = 16;
	localparam int PARAM_W     = 32;
	localparam int TASK_W      = 8;
	localparam int PRIO_W      = 8;
	localparam int MSG_W       = CMD_W + PARAM_W;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 8;
	localparam int CAP_FIELD_W = 5;

	typedef logic [1:0]            func_t;
	typedef logic [3:0]            status_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [PARAM_W-1:0]    param_t;
	typedef logic [TASK_W-1:0]     task_t;
	typedef logic [PRIO_W-1:0]     prio_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam func_t FUNC_SEND_REAR  = 2'd0;
	localparam func_t FUNC_SEND_FRONT = 2'd1;
	localparam func_t FUNC_RECEIVE    = 2'd2;
	localparam func_t FUNC_CANCEL     = 2'd3;

	localparam status_t ST_QUEUED       = 4'd0;
	localparam status_t ST_HANDED       = 4'd1;
	localparam status_t ST_FULL         = 4'd2;
	localparam status_t ST_RECEIVED     = 4'd3;
	localparam status_t ST_EMPTY        = 4'd4;
	localparam status_t ST_WAITING      = 4'd5;
	localparam status_t ST_WAITERS_FULL = 4'd6;
	localparam status_t ST_TIMED_OUT    = 4'd7;
	localparam status_t ST_NOT_WAITING  = 4'd8;

	localparam cmd_t CMD_EMPTY = 16'h0000;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	localparam cfg_index_t REG_QUEUE_MODE      = 4'd0;
	localparam cfg_index_t REG_BUFFER_CAPACITY = 4'd1;

endpackage

// ===== rtl/mqw_if.sv =====
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface mqw_req_if import mqw_pkg::*; ();
	logic   valid;
	logic   ready;
	func_t  func;
	cmd_t   msg_cmd;
	param_t msg_param;
	task_t  task_id;
	prio_t  task_prio;
	logic   may_wait;

	modport source (output valid, output func, output msg_cmd, output msg_param,
		output task_id, output task_prio, output may_wait, input ready);
	modport sink (input valid, input func, input msg_cmd, input msg_param,
		input task_id, input task_prio, input may_wait, output ready);
endinterface

interface mqw_rsp_if import mqw_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	cmd_t    out_cmd;
	param_t  out_param;
	task_t   woken_task;

	modport source (output valid, output status, output out_cmd, output out_param,
		output woken_task, input ready);
	modport sink (input valid, input status, input out_cmd, input out_param,
		input woken_task, output ready);
endinterface

interface mqw_cfg_if import mqw_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  value;

	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

// ===== rtl/mqw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mqw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/message_queue_with_waiters_top.sv =====
// Message queue engine: message deque and waiting-task list, both held in RAM.
//
//  Channel  Dir  Handshake     Payload
//  req      in   valid/ready   func, msg_cmd, msg_param, task_id, task_prio, may_wait
//  rsp      out  valid/ready   status, out_cmd, out_param, woken_task
//  cfg      in   valid/ready   index, value (ready is always high)
//
// Buffered or failed sends, empty receives and waiter registrations go straight to the finish
// state; a receive from the buffer first reads the message RAM. A handoff or a matching cancel
// reads k waiters (one in arrival mode, all in priority mode, up to the match for a cancel),
// and the m entries behind the chosen one move up, a read and a write each. A cancel that
// matches nothing reads all waiters. A fill count bounds the list, so reset clears no RAM.
// A new item is taken while a result waits on rsp; a finished item then holds until it drains.
`timescale 1ns / 1ps
`include "message_queue_with_waiters_top_defines.svh"

module message_queue_with_waiters_top import mqw_pkg::*; #(
	parameter int BUFFER_DEPTH = 16,
	parameter int MAX_WAITERS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mqw_req_if.sink   req,
	mqw_rsp_if.source rsp,
	mqw_cfg_if.sink   cfg
);

	localparam int CW  = $clog2(BUFFER_DEPTH + 1);
	localparam int BAW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int WCW = $clog2(MAX_WAITERS + 1);
	localparam int WAW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CAP_RESET = (16 > BUFFER_DEPTH) ? BUFFER_DEPTH : 16;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_MSG_RD   = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_SHIFT    = 3'd3;
	localparam logic [2:0] S_SHIFT_WR = 3'd4;
	localparam logic [2:0] S_FINISH   = 3'd5;

	localparam logic [1:0] K_FIFO   = 2'd0;
	localparam logic [1:0] K_PRIO   = 2'd1;
	localparam logic [1:0] K_CANCEL = 2'd2;

	typedef struct packed {
		task_t task_id;
		prio_t prio;
	} waiter_t;

	// Control state
	logic [2:0]     state_q, state_d;
	logic           mode_q, mode_d;
	logic [CW-1:0]  cap_q, cap_d;
	logic [BAW-1:0] wp_q, wp_d;
	logic [BAW-1:0] rp_q, rp_d;
	logic [CW-1:0]  msg_count_q, msg_count_d;
	logic [WCW-1:0] wcount_q, wcount_d;
	logic           rsp_valid_q, rsp_valid_d;

	// Working and result registers
	logic [1:0]     kind_q, kind_d;
	cmd_t           itm_cmd_q, itm_cmd_d;
	param_t         itm_param_q, itm_param_d;
	task_t          itm_task_q, itm_task_d;
	logic [WAW-1:0] chk_idx_q, chk_idx_d;
	logic [WAW-1:0] best_idx_q, best_idx_d;
	prio_t          best_prio_q, best_prio_d;
	task_t          best_task_q, best_task_d;
	status_t        res_status_q, res_status_d;
	cmd_t           res_cmd_q, res_cmd_d;
	param_t         res_param_q, res_param_d;
	task_t          res_woken_q, res_woken_d;
	status_t        rsp_status_q, rsp_status_d;
	cmd_t           rsp_cmd_q, rsp_cmd_d;
	param_t         rsp_param_q, rsp_param_d;
	task_t          rsp_woken_q, rsp_woken_d;

	// RAM ports
	logic             m_we, m_re;
	logic [BAW-1:0]   m_waddr, m_raddr;
	logic [MSG_W-1:0] m_wdata, m_rdata;
	logic             w_we, w_re;
	logic [WAW-1:0]   w_waddr, w_raddr;
	waiter_t          w_wdata, w_rdata;

	logic           req_fire, cfg_fire, rsp_free;
	logic [CW-1:0]  cap_m1;
	logic [BAW-1:0] wp_inc, rp_inc, rp_dec;
	logic           chk_last, sh_last, w_upd;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.out_cmd    = rsp_cmd_q;
	assign rsp.out_param  = rsp_param_q;
	assign rsp.woken_task = rsp_woken_q;

	// Ring pointers wrap at the configured capacity, not at the RAM depth.
	assign cap_m1 = cap_q - CW'(1);
	assign wp_inc = ((CW'(wp_q) + CW'(1)) == cap_q) ? '0 : wp_q + BAW'(1);
	assign rp_inc = ((CW'(rp_q) + CW'(1)) == cap_q) ? '0 : rp_q + BAW'(1);
	assign rp_dec = (rp_q == '0) ? cap_m1[BAW-1:0] : rp_q - BAW'(1);

	assign chk_last = (WCW'(chk_idx_q) + WCW'(1)) == wcount_q;
	assign sh_last  = (WCW'(best_idx_q) + WCW'(1)) == wcount_q;
	assign w_upd    = (chk_idx_q == '0) || (w_rdata.prio < best_prio_q);

	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		cap_d        = cap_q;
		wp_d         = wp_q;
		rp_d         = rp_q;
		msg_count_d  = msg_count_q;
		wcount_d     = wcount_q;
		kind_d       = kind_q;
		itm_cmd_d    = itm_cmd_q;
		itm_param_d  = itm_param_q;
		itm_task_d   = itm_task_q;
		chk_idx_d    = chk_idx_q;
		best_idx_d   = best_idx_q;
		best_prio_d  = best_prio_q;
		best_task_d  = best_task_q;
		res_status_d = res_status_q;
		res_cmd_d    = res_cmd_q;
		res_param_d  = res_param_q;
		res_woken_d  = res_woken_q;
		rsp_status_d = rsp_status_q;
		rsp_cmd_d    = rsp_cmd_q;
		rsp_param_d  = rsp_param_q;
		rsp_woken_d  = rsp_woken_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;

		m_we    = 1'b0;
		m_waddr = wp_q;
		m_wdata = {req.msg_cmd, req.msg_param};
		m_re    = 1'b0;
		m_raddr = rp_q;
		w_we    = 1'b0;
		w_waddr = wcount_q[WAW-1:0];
		w_wdata = '{task_id: req.task_id, prio: req.task_prio};
		w_re    = 1'b0;
		w_raddr = chk_idx_q + WAW'(1);

		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					itm_cmd_d   = req.msg_cmd;
					itm_param_d = req.msg_param;
					itm_task_d  = req.task_id;
					res_cmd_d   = CMD_EMPTY;
					res_param_d = '0;
					res_woken_d = '0;
					chk_idx_d   = '0;
					best_idx_d  = '0;
					state_d     = S_FINISH;
					unique case (req.func)
						FUNC_SEND_REAR, FUNC_SEND_FRONT: begin
							if (wcount_q != '0) begin
								kind_d  = (mode_q == MODE_PRIO) ? K_PRIO : K_FIFO;
								w_re    = 1'b1;
								w_raddr = '0;
								state_d = S_SCAN;
							end else if (msg_count_q < cap_q) begin
								m_we = 1'b1;
								if (req.func == FUNC_SEND_REAR) begin
									m_waddr = wp_q;
									wp_d    = wp_inc;
								end else begin
									m_waddr = rp_dec;
									rp_d    = rp_dec;
								end
								msg_count_d  = msg_count_q + CW'(1);
								res_status_d = ST_QUEUED;
							end else begin
								res_status_d = ST_FULL;
							end
						end
						FUNC_RECEIVE: begin
							if (msg_count_q != '0 && cap_q != '0) begin
								m_re         = 1'b1;
								m_raddr      = rp_q;
								rp_d         = rp_inc;
								msg_count_d  = msg_count_q - CW'(1);
								res_status_d = ST_RECEIVED;
								state_d      = S_MSG_RD;
							end else if (!req.may_wait) begin
								res_status_d = ST_EMPTY;
							end else if (wcount_q >= WCW'(MAX_WAITERS)) begin
								res_status_d = ST_WAITERS_FULL;
							end else begin
								w_we         = 1'b1;
								w_waddr      = wcount_q[WAW-1:0];
								wcount_d     = wcount_q + WCW'(1);
								res_status_d = ST_WAITING;
							end
						end
						FUNC_CANCEL: begin
							if (wcount_q == '0) begin
								res_status_d = ST_NOT_WAITING;
							end else begin
								kind_d  = K_CANCEL;
								w_re    = 1'b1;
								w_raddr = '0;
								state_d = S_SCAN;
							end
						end
					endcase
				end
			end
			S_MSG_RD: begin
				res_cmd_d   = m_rdata[MSG_W-1:PARAM_W];
				res_param_d = m_rdata[PARAM_W-1:0];
				state_d     = S_FINISH;
			end
			S_SCAN: begin
				// The entry read last cycle is judged while the next one is fetched.
				chk_idx_d = chk_idx_q + WAW'(1);
				w_re      = !chk_last;
				unique case (kind_q)
					K_FIFO: begin
						best_idx_d   = chk_idx_q;
						res_status_d = ST_HANDED;
						res_cmd_d    = itm_cmd_q;
						res_param_d  = itm_param_q;
						res_woken_d  = w_rdata.task_id;
						state_d      = S_SHIFT;
					end
					K_PRIO: begin
						if (w_upd) begin
							best_idx_d  = chk_idx_q;
							best_prio_d = w_rdata.prio;
							best_task_d = w_rdata.task_id;
						end
						if (chk_last) begin
							res_status_d = ST_HANDED;
							res_cmd_d    = itm_cmd_q;
							res_param_d  = itm_param_q;
							res_woken_d  = w_upd ? w_rdata.task_id : best_task_q;
							state_d      = S_SHIFT;
						end
					end
					K_CANCEL: begin
						if (w_rdata.task_id == itm_task_q) begin
							best_idx_d   = chk_idx_q;
							res_status_d = ST_TIMED_OUT;
							state_d      = S_SHIFT;
						end else if (chk_last) begin
							res_status_d = ST_NOT_WAITING;
							state_d      = S_FINISH;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SHIFT: begin
				// Close the gap: each entry behind the removed one moves up by one.
				if (sh_last) begin
					wcount_d = wcount_q - WCW'(1);
					state_d  = S_FINISH;
				end else begin
					w_re    = 1'b1;
					w_raddr = best_idx_q + WAW'(1);
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				w_we       = 1'b1;
				w_waddr    = best_idx_q;
				w_wdata    = w_rdata;
				best_idx_d = best_idx_q + WAW'(1);
				state_d    = S_SHIFT;
			end
			S_FINISH: begin
				if (rsp_free) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = res_status_q;
					rsp_cmd_d    = res_cmd_q;
					rsp_param_d  = res_param_q;
					rsp_woken_d  = res_woken_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A capacity write empties the buffer and overrides any pointer update.
		if (cfg_fire) begin
			if (cfg.index == REG_QUEUE_MODE) begin
				mode_d = cfg.value[0];
			end else if (cfg.index == REG_BUFFER_CAPACITY) begin
				if (32'(cfg.value[CAP_FIELD_W-1:0]) > 32'(BUFFER_DEPTH)) begin
					cap_d = CW'(BUFFER_DEPTH);
				end else begin
					cap_d = CW'(cfg.value[CAP_FIELD_W-1:0]);
				end
				wp_d        = '0;
				rp_d        = '0;
				msg_count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_FIFO;
			cap_q       <= CW'(CAP_RESET);
			wp_q        <= '0;
			rp_q        <= '0;
			msg_count_q <= '0;
			wcount_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			cap_q       <= cap_d;
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			msg_count_q <= msg_count_d;
			wcount_q    <= wcount_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q       <= kind_d;
		itm_cmd_q    <= itm_cmd_d;
		itm_param_q  <= itm_param_d;
		itm_task_q   <= itm_task_d;
		chk_idx_q    <= chk_idx_d;
		best_idx_q   <= best_idx_d;
		best_prio_q  <= best_prio_d;
		best_task_q  <= best_task_d;
		res_status_q <= res_status_d;
		res_cmd_q    <= res_cmd_d;
		res_param_q  <= res_param_d;
		res_woken_q  <= res_woken_d;
		rsp_status_q <= rsp_status_d;
		rsp_cmd_q    <= rsp_cmd_d;
		rsp_param_q  <= rsp_param_d;
		rsp_woken_q  <= rsp_woken_d;
	end

	mqw_ram #(
		.WIDTH(MSG_W),
		.DEPTH(BUFFER_DEPTH)
	) u_msg_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	mqw_ram #(
		.WIDTH($bits(waiter_t)),
		.DEPTH(MAX_WAITERS)
	) u_waiter_ram (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_waddr),
		.wdata(w_wdata),
		.re   (w_re),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	`MQW_ASSERT(a_count_within_cap, msg_count_q <= cap_q, "message count above capacity")
	`MQW_ASSERT(a_waiters_bounded, wcount_q <= WCW'(MAX_WAITERS), "waiter count above limit")
	`MQW_ASSERT_NEXT(a_cap_write_empties, cfg.valid && cfg.index == REG_BUFFER_CAPACITY, msg_count_q == '0 && wp_q == '0 && rp_q == '0, "capacity write did not empty the buffer")

endmodule

// ===== verif/message_queue_with_waiters_top_tb.sv =====
// Self-checking testbench for the message queue engine with waiting tasks.
`timescale 1ns / 1ps

module message_queue_with_waiters_top_tb;
	import mqw_pkg::*;

	localparam int DEPTH        = 16;
	localparam int WAITERS      = 16;
	localparam int PHASE_ITEMS  = 80;
	localparam int LONG_HOLD    = 80;
	localparam int SETTLE       = 20;
	localparam int MAX_SHOWN    = 10;
	localparam int RUN_LIMIT    = 500000;
	localparam int PHASES       = 8;

	typedef struct packed {
		func_t   func;
		cmd_t    msg_cmd;
		param_t  msg_param;
		task_t   task_id;
		prio_t   task_prio;
		logic    may_wait;
	} queue_request_t;

	typedef struct packed {
		status_t status;
		cmd_t    out_cmd;
		param_t  out_param;
		task_t   woken_task;
	} queue_reply_t;

	logic clk;
	logic arst_n;

	mqw_req_if req_ch ();
	mqw_rsp_if rsp_ch ();
	mqw_cfg_if cfg_ch ();

	message_queue_with_waiters_top #(
		.BUFFER_DEPTH(DEPTH),
		.MAX_WAITERS (WAITERS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	queue_request_t request_backlog[$];
	queue_reply_t   predicted_replies[$];
	queue_request_t cur_request;

	// Shadow state of the engine.
	logic        mode_shadow;
	int unsigned cap_shadow;
	logic [MSG_W-1:0] slot_shadow [DEPTH];
	int unsigned wr_idx;
	int unsigned rd_idx;
	int unsigned msg_count;
	task_t       waiter_task [WAITERS];
	prio_t       waiter_prio [WAITERS];
	int unsigned waiter_count;

	int unsigned tx_gap;
	int unsigned rx_stall;
	int unsigned hold_left;
	logic        hold_start;
	logic        tx_gaps_on;
	logic        rx_gaps_on;
	int unsigned cycle_count;
	int unsigned requests_sent;
	int unsigned replies_seen;
	int unsigned mismatches;
	int unsigned settings_used;
	int unsigned status_seen [16];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic queue_request_t make_request(func_t f, cmd_t c, param_t p, task_t t,
			prio_t pr, logic w);
		queue_request_t r;
		r.func      = f;
		r.msg_cmd   = c;
		r.msg_param = p;
		r.task_id   = t;
		r.task_prio = pr;
		r.may_wait  = w;
		return r;
	endfunction

	// Task ids mostly stay in a narrow band so that cancels often match.
	function automatic queue_request_t random_request(logic waiter_heavy);
		queue_request_t r;
		int unsigned pick;
		r.msg_cmd   = cmd_t'($urandom);
		r.msg_param = $urandom;
		r.task_id   = ($urandom_range(0, 9) == 0) ? task_t'($urandom) : task_t'($urandom_range(0, 7));
		r.task_prio = ($urandom_range(0, 4) == 0) ? prio_t'($urandom) : prio_t'($urandom_range(0, 3));
		r.may_wait  = waiter_heavy ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		if (waiter_heavy)
			r.func = (pick < 25) ? FUNC_SEND_REAR : (pick < 35) ? FUNC_SEND_FRONT :
				(pick < 80) ? FUNC_RECEIVE : FUNC_CANCEL;
		else
			r.func = (pick < 35) ? FUNC_SEND_REAR : (pick < 55) ? FUNC_SEND_FRONT :
				(pick < 90) ? FUNC_RECEIVE : FUNC_CANCEL;
		return r;
	endfunction

	// Removing a waiter closes the gap so the list stays in arrival order.
	function automatic void drop_waiter(int unsigned pos);
		for (int unsigned i = pos; i + 1 < waiter_count; i++) begin
			waiter_task[i] = waiter_task[i + 1];
			waiter_prio[i] = waiter_prio[i + 1];
		end
		waiter_count--;
	endfunction

	function automatic queue_reply_t predict_queue_op(queue_request_t r);
		queue_reply_t res;
		int unsigned best;
		logic found;
		res.status     = ST_FULL;
		res.out_cmd    = CMD_EMPTY;
		res.out_param  = '0;
		res.woken_task = '0;
		found = 1'b0;
		if (r.func == FUNC_SEND_REAR || r.func == FUNC_SEND_FRONT) begin
			if (waiter_count > 0) begin
				best = 0;
				if (mode_shadow == MODE_PRIO)
					for (int unsigned i = 1; i < waiter_count; i++)
						if (waiter_prio[i] < waiter_prio[best])
							best = i;
				res.status     = ST_HANDED;
				res.woken_task = waiter_task[best];
				res.out_cmd    = r.msg_cmd;
				res.out_param  = r.msg_param;
				drop_waiter(best);
			end else if (msg_count < cap_shadow) begin
				if (r.func == FUNC_SEND_REAR) begin
					slot_shadow[wr_idx] = {r.msg_cmd, r.msg_param};
					wr_idx = (wr_idx + 1) % cap_shadow;
				end else begin
					rd_idx = (rd_idx == 0) ? cap_shadow - 1 : rd_idx - 1;
					slot_shadow[rd_idx] = {r.msg_cmd, r.msg_param};
				end
				msg_count++;
				res.status = ST_QUEUED;
			end
		end else if (r.func == FUNC_RECEIVE) begin
			if (msg_count != 0) begin
				{res.out_cmd, res.out_param} = slot_shadow[rd_idx];
				rd_idx = (rd_idx + 1) % cap_shadow;
				msg_count--;
				res.status = ST_RECEIVED;
			end else if (!r.may_wait) begin
				res.status = ST_EMPTY;
			end else if (waiter_count >= WAITERS) begin
				res.status = ST_WAITERS_FULL;
			end else begin
				waiter_task[waiter_count] = r.task_id;
				waiter_prio[waiter_count] = r.task_prio;
				waiter_count++;
				res.status = ST_WAITING;
			end
		end else begin
			res.status = ST_NOT_WAITING;
			for (int unsigned i = 0; i < waiter_count; i++) begin
				if (!found && waiter_task[i] == r.task_id) begin
					drop_waiter(i);
					res.status = ST_TIMED_OUT;
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

	task automatic write_reg(cfg_index_t idx, cfg_data_t val);
		int unsigned c;
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.value <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_QUEUE_MODE) begin
			mode_shadow = val[0];
		end else begin
			c = 32'(val[CAP_FIELD_W-1:0]);
			cap_shadow = (c > DEPTH) ? DEPTH : c;
			wr_idx = 0;
			rd_idx = 0;
			msg_count = 0;
		end
	endtask

	task automatic wait_idle();
		while (request_backlog.size() != 0 || req_ch.valid || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Request side: presents the backlog one item at a time, with random gaps when they are on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			tx_gap       <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predicted_replies.push_back(predict_queue_op(cur_request));
				requests_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (tx_gap != 0) begin
					req_ch.valid <= 1'b0;
					tx_gap       <= tx_gap - 1;
				end else if (request_backlog.size() != 0) begin
					cur_request = request_backlog.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.func      <= cur_request.func;
					req_ch.msg_cmd   <= cur_request.msg_cmd;
					req_ch.msg_param <= cur_request.msg_param;
					req_ch.task_id   <= cur_request.task_id;
					req_ch.task_prio <= cur_request.task_prio;
					req_ch.may_wait  <= cur_request.may_wait;
					tx_gap           <= tx_gaps_on ? pick_gap() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Reply side: checks each item against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : reply_side
		queue_reply_t got;
		queue_reply_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_stall     <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.status, rsp_ch.out_cmd, rsp_ch.out_param, rsp_ch.woken_task};
				replies_seen++;
				status_seen[got.status]++;
				if (predicted_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("[%0t] unexpected reply: status %0d cmd %h param %h woken %h",
							$time, got.status, got.out_cmd, got.out_param, got.woken_task);
				end else begin
					want = predicted_replies.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display({"[%0t] reply mismatch: expected status %0d cmd %h param %h ",
								"woken %h, got status %0d cmd %h param %h woken %h"}, $time,
								want.status, want.out_cmd, want.out_param, want.woken_task,
								got.status, got.out_cmd, got.out_param, got.woken_task);
					end
				end
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rsp_ch.ready <= 1'b0;
				rx_stall     <= rx_stall - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rx_gaps_on && $urandom_range(0, 99) < 20)
					rx_stall <= pick_gap();
			end
		end
	end

	// Long back-pressure on the reply side, counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_start)
			hold_left <= LONG_HOLD;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("run stopped after %0d cycles with %0d replies outstanding", cycle_count,
				predicted_replies.size());
			$display("message_queue_with_waiters_top_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic      mode_seq [PHASES];
		cfg_data_t cap_seq [PHASES];
		int unsigned leftover;
		mode_seq = '{MODE_PRIO, MODE_FIFO, MODE_PRIO, MODE_FIFO, MODE_PRIO, MODE_FIFO,
			MODE_PRIO, MODE_FIFO};
		cap_seq  = '{8'd4, 8'd0, 8'd16, 8'd1, 8'd31, 8'd7, 8'd20, 8'd2};
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FUNC_SEND_REAR;
		req_ch.msg_cmd   = '0;
		req_ch.msg_param = '0;
		req_ch.task_id   = '0;
		req_ch.task_prio = '0;
		req_ch.may_wait  = 1'b0;
		rsp_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_QUEUE_MODE;
		cfg_ch.value     = '0;
		hold_start       = 1'b0;
		tx_gaps_on       = 1'b1;
		rx_gaps_on       = 1'b1;
		cycle_count      = 0;
		requests_sent    = 0;
		replies_seen     = 0;
		mismatches       = 0;
		settings_used    = 1;
		foreach (status_seen[i])
			status_seen[i] = 0;
		mode_shadow  = MODE_FIFO;
		cap_shadow   = DEPTH;
		wr_idx       = 0;
		rd_idx       = 0;
		msg_count    = 0;
		waiter_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: empty receive, stray cancel, extremes, front wrap, duplicate waiter.
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'h00, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_CANCEL, 16'h0000, 32'h0, 8'h05, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
			8'hFF, 1'b1));
		request_backlog.push_back(make_request(FUNC_SEND_FRONT, 16'h0000, 32'h0, 8'h00, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'h01, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'h01, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'h12, 8'hFF, 1'b1));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'h12, 8'h00, 1'b1));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0000, 32'h0, 8'hED, 8'h80, 1'b1));
		request_backlog.push_back(make_request(FUNC_CANCEL, 16'h0000, 32'h0, 8'h12, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'hA5A5, 32'h5A5A_5A5A, 8'h00,
			8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_FRONT, 16'h1234, 32'h89AB_CDEF, 8'h00,
			8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_CANCEL, 16'h0000, 32'h0, 8'hED, 8'h00, 1'b0));
		wait_idle();

		// Priority order with a tie, under a capacity that saturates.
		write_reg(REG_QUEUE_MODE, 8'(MODE_PRIO));
		write_reg(REG_BUFFER_CAPACITY, 8'd31);
		settings_used++;
		@(negedge clk);
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0, 32'h0, 8'h01, 8'h03, 1'b1));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0, 32'h0, 8'h02, 8'h01, 1'b1));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0, 32'h0, 8'h03, 8'h01, 1'b1));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'h0101, 32'h1, 8'h0, 8'h0, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_FRONT, 16'h0202, 32'h2, 8'h0, 8'h0, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'h0303, 32'h3, 8'h0, 8'h0, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'hC3C3, 32'h3C3C_3C3C, 8'h0,
			8'h0, 1'b0));
		wait_idle();

		// Zero capacity drops the buffered message; only direct handoff works.
		write_reg(REG_BUFFER_CAPACITY, 8'd0);
		settings_used++;
		@(negedge clk);
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0, 32'h0, 8'h07, 8'h00, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_REAR, 16'h7777, 32'h7, 8'h0, 8'h0, 1'b0));
		request_backlog.push_back(make_request(FUNC_SEND_FRONT, 16'h8888, 32'h8, 8'h0, 8'h0, 1'b0));
		request_backlog.push_back(make_request(FUNC_RECEIVE, 16'h0, 32'h0, 8'h07, 8'h10, 1'b1));
		request_backlog.push_back(make_request(FUNC_SEND_FRONT, 16'h9999, 32'h9, 8'h0, 8'h0, 1'b0));
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_QUEUE_MODE, 8'(mode_seq[p]));
			// One phase keeps its buffer so that only the serving rule changes.
			if (p != 5)
				write_reg(REG_BUFFER_CAPACITY, cap_seq[p]);
			settings_used++;
			@(negedge clk);
			tx_gaps_on = (p % 3 != 0);
			rx_gaps_on = (p % 4 != 1);
			// The buffer is empty after a capacity write, so these all try to wait.
			if (p == 1 || p == 4)
				for (int k = 0; k < WAITERS + 2; k++)
					request_backlog.push_back(make_request(FUNC_RECEIVE, cmd_t'($urandom),
						$urandom, task_t'(k), prio_t'($urandom_range(0, 3)), 1'b1));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				request_backlog.push_back(random_request(p % 2));
				if (p == 6 && k == PHASE_ITEMS / 2)
					wait_idle();
			end
			if (p == 2) begin
				// Hold replies off while the sender keeps offering items.
				for (int k = 0; k < 24; k++)
					request_backlog.push_back(random_request(1'b0));
				hold_start = 1'b1;
				while (hold_left == 0)
					@(negedge clk);
				hold_start = 1'b0;
			end
			wait_idle();
		end

		repeat (SETTLE) @(posedge clk);
		leftover = predicted_replies.size();
		if (leftover != 0)
			$display("%0d predicted replies never arrived", leftover);
		$display("covered %0d items and %0d replies over %0d register settings",
			requests_sent, replies_seen, settings_used);
		$display({"statuses: queued %0d, handed %0d, full %0d, received %0d, empty %0d, ",
			"waiting %0d, waiters full %0d, timed out %0d, not waiting %0d"},
			status_seen[ST_QUEUED], status_seen[ST_HANDED], status_seen[ST_FULL],
			status_seen[ST_RECEIVED], status_seen[ST_EMPTY], status_seen[ST_WAITING],
			status_seen[ST_WAITERS_FULL], status_seen[ST_TIMED_OUT], status_seen[ST_NOT_WAITING]);
		if (mismatches == 0 && leftover == 0) begin
			$display("message_queue_with_waiters_top_tb: done, clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("message_queue_with_waiters_top_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mqw_pkg.sv
rtl/mqw_if.sv
rtl/mqw_ram.sv
rtl/message_queue_with_waiters_top.sv
verif/message_queue_with_waiters_top_tb.sv
